// File: src/bgr_pkg.sv
// shared constants and types for the bilinear grid rescaler
// no dependencies; used by the top level for defaults, codes and register map
`timescale 1ns / 1ps
`default_nettype none

package bgr_pkg;

	// default sizes for the top level parameters
	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int COORD_BITS    = 8;
	localparam int FRAC_BITS     = 16;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	// register reset values
	localparam logic [8:0]  WIDTH_RST  = 9'd256;
	localparam logic [8:0]  HEIGHT_RST = 9'd256;
	localparam logic [23:0] XSTEP_RST  = 24'h010000;
	localparam logic [23:0] YSTEP_RST  = 24'h010000;

	// register map, word index
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_XSTEP  = 2'd2,
		REG_YSTEP  = 2'd3
	} reg_idx_t;

	// request kind carried on tuser
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} opcode_t;

endpackage

`default_nettype wire

// File: src/bgr_grid_ram.sv
// source grid store: one write port, two registered read ports
// no dependencies; instantiated twice by the top level
`timescale 1ns / 1ps
`default_nettype none

module bgr_grid_ram #(
	parameter int ADDR_BITS = 16,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr_a,
	input  logic [ADDR_BITS-1:0] raddr_b,
	output logic [DATA_BITS-1:0] rdata_a,
	output logic [DATA_BITS-1:0] rdata_b
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [DATA_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: src/bilinear_grid_rescaler.sv
// bilinear grid rescaler top level: stream channels, apb registers, 8-stage pipeline
// depends on bgr_pkg and bgr_grid_ram
//
// usage
//   s_* carries requests. tuser is the opcode: load stores sample_in at
//   (coord_x, coord_y), compute asks for one output sample at the output
//   coordinate (coord_x, coord_y). m_* carries one sample_out per compute;
//   loads give no result.
//   registers (apb, byte address 4*i): source_width, source_height, x_step,
//   y_step; write them only while no request is in flight.
// throughput
//   one request per cycle, sustained while m_tready stays high. the four
//   neighbor reads are served together by two copies of the grid store,
//   each with two read ports.
// reset
//   pipeline empties and registers return to their defaults; grid contents
//   are undefined until loaded.
// stall
//   when m_tready is low the result is held and stages behind it fill up;
//   bubbles are squeezed out, and s_tready drops only once every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_rescaler #(
	parameter int MAX_WIDTH   = bgr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = bgr_pkg::MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = bgr_pkg::SAMPLE_BITS_DEF,
	localparam int SMP_BYTES  = (SAMPLE_BITS + 7) / 8,
	localparam int IN_DW      = 2 * bgr_pkg::COORD_BITS + 8 * SMP_BYTES,
	localparam int OUT_DW     = 8 * SMP_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_DW-1:0]                   s_tdata,  // coord_x, coord_y, sample_in
	input  logic                               s_tuser,  // opcode
	// result channel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_DW-1:0]                  m_tdata,  // sample_out
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bgr_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [bgr_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [bgr_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = bgr_pkg::COORD_BITS;
	localparam int FB   = bgr_pkg::FRAC_BITS;
	localparam int XB   = $clog2(MAX_WIDTH);
	localparam int YB   = $clog2(MAX_HEIGHT);
	localparam int WB   = XB + 1;
	localparam int HB   = YB + 1;
	// stored columns and rows: coordinates of a load never pass 8 bits
	localparam int SXB  = (XB < CB) ? XB : CB;
	localparam int SYB  = (YB < CB) ? YB : CB;
	localparam int AB   = SXB + SYB;
	localparam int PB   = CB + 24;
	localparam int VPB  = SB + FB + 2;

	// ---------------------------------------------------------------
	// configuration registers
	logic [8:0]  src_width_q;
	logic [8:0]  src_height_q;
	logic [23:0] x_step_q;
	logic [23:0] y_step_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bgr_pkg::WIDTH_RST;
			src_height_q <= bgr_pkg::HEIGHT_RST;
			x_step_q     <= bgr_pkg::XSTEP_RST;
			y_step_q     <= bgr_pkg::YSTEP_RST;
		end else if (cfg_wr) begin
			case (bgr_pkg::reg_idx_t'(paddr[3:2]))
				bgr_pkg::REG_WIDTH:  src_width_q  <= pwdata[8:0];
				bgr_pkg::REG_HEIGHT: src_height_q <= pwdata[8:0];
				bgr_pkg::REG_XSTEP:  x_step_q     <= pwdata[23:0];
				bgr_pkg::REG_YSTEP:  y_step_q     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (bgr_pkg::reg_idx_t'(paddr[3:2]))
			bgr_pkg::REG_WIDTH:  prdata = 32'(src_width_q);
			bgr_pkg::REG_HEIGHT: prdata = 32'(src_height_q);
			bgr_pkg::REG_XSTEP:  prdata = 32'(x_step_q);
			bgr_pkg::REG_YSTEP:  prdata = 32'(y_step_q);
			default:             prdata = '0;
		endcase
	end

	// sizes in use, saturated into 1..max
	logic [WB-1:0] w_use;
	logic [HB-1:0] h_use;
	logic [XB-1:0] w_m1;
	logic [YB-1:0] h_m1;

	always_comb begin
		if (src_width_q == 9'd0) begin
			w_use = WB'(1);
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			w_use = WB'(MAX_WIDTH);
		end else begin
			w_use = WB'(src_width_q);
		end
		if (src_height_q == 9'd0) begin
			h_use = HB'(1);
		end else if (32'(src_height_q) > 32'(MAX_HEIGHT)) begin
			h_use = HB'(MAX_HEIGHT);
		end else begin
			h_use = HB'(src_height_q);
		end
		w_m1 = XB'(w_use - WB'(1));
		h_m1 = YB'(h_use - HB'(1));
	end

	// ---------------------------------------------------------------
	// stage advance chain: a stage loads when it is empty or moves on
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic take1, take2, take3, take4, take5, take6, take7, take8;
	bgr_pkg::opcode_t op_s3;

	assign take8 = !v_s8 || m_tready;
	assign take7 = !v_s7 || take8;
	assign take6 = !v_s6 || take7;
	assign take5 = !v_s5 || take6;
	assign take4 = !v_s4 || take5;
	assign take3 = !v_s3 || take4;
	assign take2 = !v_s2 || take3;
	assign take1 = !v_s1 || take2;

	assign s_tready = take1;

	// valid bits; loads leave the pipe at the grid write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (take1) v_s1 <= s_tvalid;
			if (take2) v_s2 <= v_s1;
			if (take3) v_s3 <= v_s2;
			if (take4) v_s4 <= v_s3 && (op_s3 == bgr_pkg::OP_COMPUTE);
			if (take5) v_s5 <= v_s4;
			if (take6) v_s6 <= v_s5;
			if (take7) v_s7 <= v_s6;
			if (take8) v_s8 <= v_s7;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: request register
	bgr_pkg::opcode_t op_s1;
	logic [CB-1:0]    cx_s1, cy_s1;
	logic [SB-1:0]    smp_s1;

	always_ff @(posedge clk) begin
		if (take1) begin
			op_s1  <= bgr_pkg::opcode_t'(s_tuser);
			cx_s1  <= s_tdata[CB-1:0];
			cy_s1  <= s_tdata[2*CB-1:CB];
			smp_s1 <= s_tdata[2*CB+SB-1:2*CB];
		end
	end

	// ---------------------------------------------------------------
	// stage 2: coordinate times step
	bgr_pkg::opcode_t op_s2;
	logic [CB-1:0]    cx_s2, cy_s2;
	logic [SB-1:0]    smp_s2;
	logic [PB-1:0]    px_s2, py_s2;

	always_ff @(posedge clk) begin
		if (take2) begin
			op_s2  <= op_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			smp_s2 <= smp_s1;
			px_s2  <= PB'(cx_s1) * PB'(x_step_q);
			py_s2  <= PB'(cy_s1) * PB'(y_step_q);
		end
	end

	// ---------------------------------------------------------------
	// stage 3: saturate indices and pick wrapped neighbors
	logic [PB-FB-1:0] xi_full, yi_full;
	logic [XB-1:0]    xi_sat, xn_nx;
	logic [YB-1:0]    yi_sat, yn_nx;

	always_comb begin
		xi_full = px_s2[PB-1:FB];
		yi_full = py_s2[PB-1:FB];
		if (32'(xi_full) >= 32'(w_use)) begin
			xi_sat = w_m1;
		end else begin
			xi_sat = xi_full[XB-1:0];
		end
		if (32'(yi_full) >= 32'(h_use)) begin
			yi_sat = h_m1;
		end else begin
			yi_sat = yi_full[YB-1:0];
		end
		xn_nx = (xi_sat == w_m1) ? '0 : XB'(xi_sat + XB'(1));
		yn_nx = (yi_sat == h_m1) ? '0 : YB'(yi_sat + YB'(1));
	end

	logic [CB-1:0]    cx_s3, cy_s3;
	logic [SB-1:0]    smp_s3;
	logic [XB-1:0]    xi_s3, xn_s3;
	logic [YB-1:0]    yi_s3, yn_s3;
	logic [FB-1:0]    xf_s3, yf_s3;

	always_ff @(posedge clk) begin
		if (take3) begin
			op_s3  <= op_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			smp_s3 <= smp_s2;
			xi_s3  <= xi_sat;
			xn_s3  <= xn_nx;
			yi_s3  <= yi_sat;
			yn_s3  <= yn_nx;
			xf_s3  <= px_s2[FB-1:0];
			yf_s3  <= py_s2[FB-1:0];
		end
	end

	// ---------------------------------------------------------------
	// stage 4: grid access; loads write, computes read four neighbors
	logic          ld_in_range;
	logic          ram_we;
	logic [AB-1:0] ram_waddr;
	logic [AB-1:0] addr00, addr01, addr10, addr11;
	logic signed [SB-1:0] p00, p01, p10, p11;

	assign ld_in_range = (32'(cx_s3) < 32'(MAX_WIDTH)) && (32'(cy_s3) < 32'(MAX_HEIGHT));
	assign ram_we      = take4 && v_s3 && (op_s3 == bgr_pkg::OP_LOAD) && ld_in_range;
	assign ram_waddr   = {cy_s3[SYB-1:0], cx_s3[SXB-1:0]};
	assign addr00      = {yi_s3[SYB-1:0], xi_s3[SXB-1:0]};
	assign addr01      = {yn_s3[SYB-1:0], xi_s3[SXB-1:0]};
	assign addr10      = {yi_s3[SYB-1:0], xn_s3[SXB-1:0]};
	assign addr11      = {yn_s3[SYB-1:0], xn_s3[SXB-1:0]};

	// left column copy
	bgr_grid_ram #(
		.ADDR_BITS (AB),
		.DATA_BITS (SB)
	) u_ram_left (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (smp_s3),
		.re      (take4),
		.raddr_a (addr00),
		.raddr_b (addr01),
		.rdata_a (p00),
		.rdata_b (p01)
	);

	// right column copy
	bgr_grid_ram #(
		.ADDR_BITS (AB),
		.DATA_BITS (SB)
	) u_ram_right (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (smp_s3),
		.re      (take4),
		.raddr_a (addr10),
		.raddr_b (addr11),
		.rdata_a (p10),
		.rdata_b (p11)
	);

	logic [FB-1:0] xf_s4, yf_s4;

	always_ff @(posedge clk) begin
		if (take4) begin
			xf_s4 <= xf_s3;
			yf_s4 <= yf_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: vertical differences times row fraction
	logic signed [SB:0]   dl, dr;
	logic signed [FB:0]   yf_ext;
	logic signed [VPB-1:0] vprod_l_s5, vprod_r_s5;
	logic signed [SB-1:0] base_l_s5, base_r_s5;
	logic [FB-1:0]        xf_s5;

	assign dl     = {p01[SB-1], p01} - {p00[SB-1], p00};
	assign dr     = {p11[SB-1], p11} - {p10[SB-1], p10};
	assign yf_ext = {1'b0, yf_s4};

	always_ff @(posedge clk) begin
		if (take5) begin
			vprod_l_s5 <= dl * yf_ext;
			vprod_r_s5 <= dr * yf_ext;
			base_l_s5  <= p00;
			base_r_s5  <= p10;
			xf_s5      <= xf_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 6: add floored products back onto the top row
	logic signed [SB+1:0] sum_l, sum_r;
	logic signed [SB-1:0] left_s6, right_s6;
	logic [FB-1:0]        xf_s6;

	assign sum_l = {{2{base_l_s5[SB-1]}}, base_l_s5} + vprod_l_s5[VPB-1:FB];
	assign sum_r = {{2{base_r_s5[SB-1]}}, base_r_s5} + vprod_r_s5[VPB-1:FB];

	always_ff @(posedge clk) begin
		if (take6) begin
			left_s6  <= sum_l[SB-1:0];
			right_s6 <= sum_r[SB-1:0];
			xf_s6    <= xf_s5;
		end
	end

	// ---------------------------------------------------------------
	// stage 7: horizontal difference times column fraction
	logic signed [SB:0]    dh;
	logic signed [FB:0]    xf_ext;
	logic signed [VPB-1:0] hprod_s7;
	logic signed [SB-1:0]  base_h_s7;

	assign dh     = {right_s6[SB-1], right_s6} - {left_s6[SB-1], left_s6};
	assign xf_ext = {1'b0, xf_s6};

	always_ff @(posedge clk) begin
		if (take7) begin
			hprod_s7  <= dh * xf_ext;
			base_h_s7 <= left_s6;
		end
	end

	// ---------------------------------------------------------------
	// stage 8: output register
	logic signed [SB+1:0] sum_h;
	logic [SB-1:0]        out_s8;

	assign sum_h = {{2{base_h_s7[SB-1]}}, base_h_s7} + hprod_s7[VPB-1:FB];

	always_ff @(posedge clk) begin
		if (take8) begin
			out_s8 <= sum_h[SB-1:0];
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = OUT_DW'(out_s8);

	// ---------------------------------------------------------------
	// checks

	// a load never turns into a result
	a_load_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(take4 && v_s3 && (op_s3 == bgr_pkg::OP_LOAD)) |=> !v_s4)
		else $error("load request reached the read stage as valid");

	// grid read data holds while the vertical stage is blocked
	a_ram_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !take5) |=> ($stable(p00) && $stable(p01) && $stable(p10) && $stable(p11)))
		else $error("grid read data changed during a stall");

	// vertical products hold while the next stage is blocked
	a_vprod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !take6) |=> (v_s5 && $stable(vprod_l_s5) && $stable(vprod_r_s5)))
		else $error("vertical stage lost or changed its item during a stall");

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !m_tready) |=> $stable(out_s8))
		else $error("result changed while waiting");

endmodule

`default_nettype wire

// File: test/bilinear_grid_rescaler_tb.sv
// self-checking bench for bilinear_grid_rescaler: stream requests in, samples out, apb setup
// depends on bgr_pkg and the rescaler rtl; predicts every sample from its own grid copy
`timescale 1ns / 1ps

module bilinear_grid_rescaler_tb;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEM_TARGET  = 1100;

	typedef struct {
		bgr_pkg::opcode_t op;
		logic [7:0]       cx;
		logic [7:0]       cy;
		logic [15:0]      value;
		bit               drain_first;
	} grid_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // coord_x, coord_y, sample_in
	logic        s_tuser = 1'b0; // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // sample_out
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state: grid copy and register copy
	logic signed [15:0] height_map [0:65535];
	logic [8:0]         cfg_width = bgr_pkg::WIDTH_RST;
	logic [8:0]         cfg_height = bgr_pkg::HEIGHT_RST;
	logic [23:0]        cfg_xstep = bgr_pkg::XSTEP_RST;
	logic [23:0]        cfg_ystep = bgr_pkg::YSTEP_RST;

	// generator bookkeeping
	bit        written [0:65535];
	grid_req_t pending_reqs [$];
	grid_req_t cur_req;
	int        issued_count = 0;
	int        accepted_count = 0;

	logic [15:0] sample_queue [$];
	int          error_count = 0;
	int          quiet_cycles = 0;

	// sender and receiver pacing
	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int hold_left = 0;
	int long_holds = 0;

	bilinear_grid_rescaler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial forever #5 clk = ~clk;

	// scale the output coordinate, clamp to the grid in use, wrap the far neighbor
	function automatic void locate_taps(input logic [7:0] cx, input logic [7:0] cy,
			output int x0, output int x1, output int y0, output int y1,
			output int fx, output int fy);
		int w, h;
		longint px, py;
		w = cfg_width;
		h = cfg_height;
		if (w < 1) w = 1;
		if (w > bgr_pkg::MAX_WIDTH_DEF) w = bgr_pkg::MAX_WIDTH_DEF;
		if (h < 1) h = 1;
		if (h > bgr_pkg::MAX_HEIGHT_DEF) h = bgr_pkg::MAX_HEIGHT_DEF;
		px = longint'(cx) * longint'(cfg_xstep);
		py = longint'(cy) * longint'(cfg_ystep);
		x0 = int'(px >> bgr_pkg::FRAC_BITS);
		y0 = int'(py >> bgr_pkg::FRAC_BITS);
		fx = int'(px & 64'hFFFF);
		fy = int'(py & 64'hFFFF);
		if (x0 >= w) x0 = w - 1;
		if (y0 >= h) y0 = h - 1;
		x1 = (x0 < w - 1) ? x0 + 1 : 0;
		y1 = (y0 < h - 1) ? y0 + 1 : 0;
	endfunction

	// linear step with a flooring shift
	function automatic longint blend(longint a, longint b, int frac);
		return a + (((b - a) * longint'(frac)) >>> bgr_pkg::FRAC_BITS);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_req(bgr_pkg::opcode_t op, logic [7:0] cx, logic [7:0] cy,
			logic [15:0] value);
		grid_req_t r;
		r.op = op;
		r.cx = cx;
		r.cy = cy;
		r.value = value;
		r.drain_first = ($urandom_range(0, 59) == 0);
		if (op == bgr_pkg::OP_LOAD)
			written[{cy, cx}] = 1'b1;
		pending_reqs.push_back(r);
		issued_count++;
	endtask

	// compute request, preceded by loads of any neighbor not yet written
	task automatic push_compute(logic [7:0] cx, logic [7:0] cy);
		int x0, x1, y0, y1, fx, fy;
		locate_taps(cx, cy, x0, x1, y0, y1, fx, fy);
		if (!written[y0 * 256 + x0]) push_req(bgr_pkg::OP_LOAD, 8'(x0), 8'(y0), pick_sample());
		if (!written[y1 * 256 + x0]) push_req(bgr_pkg::OP_LOAD, 8'(x0), 8'(y1), pick_sample());
		if (!written[y0 * 256 + x1]) push_req(bgr_pkg::OP_LOAD, 8'(x1), 8'(y0), pick_sample());
		if (!written[y1 * 256 + x1]) push_req(bgr_pkg::OP_LOAD, 8'(x1), 8'(y1), pick_sample());
		push_req(bgr_pkg::OP_COMPUTE, cx, cy, 16'($urandom));
	endtask

	// apb write: setup then access, register updates at the access edge
	task automatic write_reg(bgr_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			bgr_pkg::REG_WIDTH:  cfg_width = val[8:0];
			bgr_pkg::REG_HEIGHT: cfg_height = val[8:0];
			bgr_pkg::REG_XSTEP:  cfg_xstep = val[23:0];
			bgr_pkg::REG_YSTEP:  cfg_ystep = val[23:0];
			default: ;
		endcase
	endtask

	// wait for every request taken and every sample back, then let loads retire
	task automatic settle();
		while (accepted_count != issued_count || sample_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver: bursts and gaps, prediction on every accepted request
	always @(posedge clk) begin : driver
		int x0, x1, y0, y1, fx, fy;
		longint left, right;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_count++;
				if (cur_req.op == bgr_pkg::OP_LOAD) begin
					height_map[{cur_req.cy, cur_req.cx}] = cur_req.value;
				end else begin
					locate_taps(cur_req.cx, cur_req.cy, x0, x1, y0, y1, fx, fy);
					left = blend(longint'(height_map[y0 * 256 + x0]),
						longint'(height_map[y1 * 256 + x0]), fy);
					right = blend(longint'(height_map[y0 * 256 + x1]),
						longint'(height_map[y1 * 256 + x1]), fy);
					sample_queue.push_back(16'(blend(left, right, fx)));
				end
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0 &&
						!(pending_reqs[0].drain_first && sample_queue.size() > 0)) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.op;
					s_tdata <= {cur_req.value, cur_req.cy, cur_req.cx};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with occasional long hold-offs to back up the pipeline
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (m_tvalid && ($urandom_range(0, 299) == 0 ||
				(long_holds == 0 && accepted_count >= 400))) begin
			hold_left = $urandom_range(40, 100);
			long_holds++;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(5, 60);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin : monitor
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sample_queue.size() == 0) begin
				$error("sample_out: no result expected, got %0d", $signed(m_tdata));
				error_count++;
			end else begin
				want = sample_queue.pop_front();
				if (m_tdata !== want) begin
					$error("sample_out: expected %0d, got %0d", $signed(want), $signed(m_tdata));
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [31:0] val;
		bit          first_phase;
		int          steps;
		first_phase = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes and unit steps: corners, far edges and wrap at full size
		push_req(bgr_pkg::OP_LOAD, 8'd0, 8'd0, 16'h7FFF);
		push_req(bgr_pkg::OP_LOAD, 8'd1, 8'd0, 16'h8000);
		push_req(bgr_pkg::OP_LOAD, 8'd0, 8'd1, 16'h8000);
		push_req(bgr_pkg::OP_LOAD, 8'd1, 8'd1, 16'h7FFF);
		push_req(bgr_pkg::OP_LOAD, 8'd255, 8'd255, 16'h7FFF);
		push_req(bgr_pkg::OP_LOAD, 8'd0, 8'd255, 16'h8000);
		push_req(bgr_pkg::OP_LOAD, 8'd255, 8'd0, 16'hFFFF);
		push_req(bgr_pkg::OP_LOAD, 8'd254, 8'd254, 16'h5555);
		push_req(bgr_pkg::OP_LOAD, 8'd255, 8'd254, 16'hAAAA);
		push_req(bgr_pkg::OP_LOAD, 8'd254, 8'd255, 16'h0001);
		push_compute(8'd0, 8'd0);
		push_compute(8'd255, 8'd255);
		push_compute(8'd254, 8'd254);
		settle();

		// half and three-quarter fractions across full-scale swings, negative products
		write_reg(bgr_pkg::REG_XSTEP, 32'h0000_8000);
		write_reg(bgr_pkg::REG_YSTEP, 32'h0000_C000);
		push_compute(8'd1, 8'd1);
		push_compute(8'd1, 8'd0);
		push_compute(8'd0, 8'd1);
		settle();

		// largest steps: index saturates at the far edge and the neighbor wraps
		write_reg(bgr_pkg::REG_XSTEP, 32'h00FF_FFFF);
		write_reg(bgr_pkg::REG_YSTEP, 32'h00FF_FFFF);
		push_compute(8'd1, 8'd1);
		push_compute(8'd255, 8'd255);
		settle();

		// size registers out of range: zero and above the maximum
		write_reg(bgr_pkg::REG_WIDTH, 32'd0);
		write_reg(bgr_pkg::REG_HEIGHT, 32'd511);
		push_compute(8'd7, 8'd3);
		push_compute(8'd0, 8'd0);
		settle();

		// zero column step on a single-row grid
		write_reg(bgr_pkg::REG_WIDTH, 32'd511);
		write_reg(bgr_pkg::REG_HEIGHT, 32'd0);
		write_reg(bgr_pkg::REG_XSTEP, 32'd0);
		push_compute(8'd200, 8'd100);

		// random phases: new register settings, then loads and computes
		while (issued_count < ITEM_TARGET) begin
			settle();
			for (int i = 0; i < 4; i++) begin
				if (first_phase || $urandom_range(0, 3) != 0) begin
					if (i < 2) begin
						case ($urandom_range(0, 7))
							0:       val = 32'd0;
							1:       val = 32'd1;
							2:       val = 32'd256;
							3:       val = $urandom_range(257, 511);
							4:       val = $urandom_range(0, 511);
							default: val = $urandom_range(2, 16);
						endcase
					end else begin
						case ($urandom_range(0, 5))
							0:       val = 32'd0;
							1:       val = 32'h00FF_FFFF;
							2:       val = 32'h0001_0000;
							3:       val = $urandom_range(0, 32'h0001_FFFF);
							4:       val = $urandom & 32'h00FF_FFFF;
							default: val = $urandom_range(0, 32'h0000_1800);
						endcase
					end
					write_reg(bgr_pkg::reg_idx_t'(i), val);
				end
			end
			first_phase = 1'b0;
			steps = $urandom_range(30, 120);
			repeat (steps) begin
				if (issued_count >= ITEM_TARGET)
					break;
				case ($urandom_range(0, 9))
					0:       push_req(bgr_pkg::OP_LOAD, 8'($urandom), 8'($urandom),
						pick_sample());
					1, 2:    push_req(bgr_pkg::OP_LOAD, 8'($urandom_range(0, 15)),
						8'($urandom_range(0, 15)), pick_sample());
					3, 4, 5: push_compute(8'($urandom), 8'($urandom));
					default: push_compute(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
				endcase
			end
		end
		settle();

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
